[rtl/glmd_pkg.sv]
// glmd_pkg: widths, types and register codes shared by the local minimum detector.
// No dependencies; every other file imports this package.

package glmd_pkg;

	localparam int DATA_W     = 16;
	localparam int MAX_COLS   = 128;
	localparam int MAX_ROWS   = 4096;
	localparam int COL_W      = 7;
	localparam int ROW_W      = 12;
	localparam int COLS_W     = 8;
	localparam int ROWS_W     = 13;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 13;

	// result slots of one transaction, in delivery order
	localparam int SLOT_ABOVE = 0;
	localparam int SLOT_LEFT  = 1;
	localparam int SLOT_SELF  = 2;
	localparam int SLOTS      = 3;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [COL_W-1:0]         col_t;
	typedef logic [ROW_W-1:0]         row_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS = 4'd0,
		REG_COLS = 4'd1
	} cfg_reg_e;

	typedef struct packed {
		data_t value;
		row_t  row;
		col_t  col;
	} result_t;

	typedef struct packed {
		logic [SLOTS-1:0]    hit;
		result_t [SLOTS-1:0] slot;
	} group_t;

	// line store access of one cycle
	typedef struct packed {
		logic  rd_en;
		col_t  rd_col;
		col_t  rd_right;
		logic  wr_en;
		col_t  wr_col;
		data_t wr_cur;
		data_t wr_above;
	} ls_req_t;

	typedef struct packed {
		data_t above;
		data_t right;
		data_t up;
	} ls_rsp_t;

	function automatic logic val_gt(input data_t a, input data_t b);
		return $signed(a) > $signed(b);
	endfunction

endpackage

[rtl/glmd_ifs.sv]
// glmd_ifs: valid/ready channels of the local minimum detector.
// Depends on glmd_pkg for field types.

interface glmd_pix_if import glmd_pkg::*;;
	logic  valid;
	logic  ready;
	data_t value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface glmd_min_if import glmd_pkg::*;;
	logic  valid;
	logic  ready;
	data_t min_value;
	row_t  min_row;
	col_t  min_col;
	logic  last;

	modport source (output valid, output min_value, output min_row, output min_col,
		output last, input ready);
	modport sink   (input valid, input min_value, input min_row, input min_col,
		input last, output ready);
endinterface

interface glmd_cfg_if import glmd_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/glmd_line_store.sv]
// glmd_line_store: previous-row and older-row memories, registered read.
// Depends on glmd_pkg; write data is forwarded to a read of the same column.

module glmd_line_store import glmd_pkg::*; (
	input  logic    clk,
	input  ls_req_t req,
	output ls_rsp_t rsp
);

	data_t prev_mem [MAX_COLS];
	data_t older_mem [MAX_COLS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			prev_mem[req.wr_col]  <= req.wr_cur;
			older_mem[req.wr_col] <= req.wr_above;
		end
		if (req.rd_en) begin
			// column written in this cycle: take the new word
			if (req.wr_en && req.wr_col == req.rd_col) begin
				rsp.above <= req.wr_cur;
				rsp.up    <= req.wr_above;
			end else begin
				rsp.above <= prev_mem[req.rd_col];
				rsp.up    <= older_mem[req.rd_col];
			end
			if (req.wr_en && req.wr_col == req.rd_right) begin
				rsp.right <= req.wr_cur;
			end else begin
				rsp.right <= prev_mem[req.rd_right];
			end
		end
	end

endmodule

[rtl/glmd_result_queue.sv]
// glmd_result_queue: holds the up to three results of one transaction and sends them in order.
// Depends on glmd_pkg and glmd_ifs.

module glmd_result_queue import glmd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  group_t          grp,
	output logic            load_ok,
	glmd_min_if.source      minima
);

	logic [SLOTS-1:0]    hit_q;
	result_t [SLOTS-1:0] slot_q;
	logic [SLOTS-1:0]    sel_mask;
	logic [SLOTS-1:0]    rest;
	result_t             sel;
	logic                fire;

	always_comb begin
		sel_mask = hit_q & (~hit_q + {{(SLOTS-1){1'b0}}, 1'b1});
		rest     = hit_q & ~sel_mask;
		sel      = slot_q[SLOT_SELF];
		if (hit_q[SLOT_ABOVE]) begin
			sel = slot_q[SLOT_ABOVE];
		end else if (hit_q[SLOT_LEFT]) begin
			sel = slot_q[SLOT_LEFT];
		end
	end

	assign fire             = minima.valid && minima.ready;
	assign minima.valid     = |hit_q;
	assign minima.min_value = sel.value;
	assign minima.min_row   = sel.row;
	assign minima.min_col   = sel.col;
	assign minima.last      = ~|rest;
	assign load_ok          = ~|hit_q || (fire && ~|rest);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= '0;
		end else if (load) begin
			hit_q <= grp.hit;
		end else if (fire) begin
			hit_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= grp.slot;
		end
	end

endmodule

[rtl/grid_local_minimum_detector_unit.sv]
// grid_local_minimum_detector_unit: streaming 4-neighbour local minimum detector, top level.
// Depends on glmd_pkg, glmd_ifs, glmd_line_store and glmd_result_queue.
//
//   channel   dir  handshake      payload
//   samples   in   valid/ready    value
//   minima    out  valid/ready    min_value, min_row, min_col, last
//   cfg       in   valid/ready    index (0 rows, 1 cols), data
//
// One element enters per cycle unless stage 1 is held; its results are registered in stage 1
// and then in the result queue before they leave. A transaction that yields k results holds
// the queue, and with it stage 1, until the last of them leaves by the single output port.
// The previous-row store takes two reads and one write per cycle.
// Reset clears position, registers and pipeline; the line stores are not cleared.
// A stalled output holds stage 1 and with it the input ready.

module grid_local_minimum_detector_unit import glmd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	glmd_pix_if.sink   samples,
	glmd_min_if.source minima,
	glmd_cfg_if.sink   cfg
);

	logic [ROWS_W-1:0] rows_q;
	logic [COLS_W-1:0] cols_q;
	logic [ROWS_W-1:0] nr;
	logic [COLS_W-1:0] nc;
	row_t              row_q;
	col_t              col_q;
	data_t             left_one_q;
	data_t             left_two_q;
	data_t             upleft_q;

	logic              in_fire;
	logic              cfg_fire;
	logic              at_last_row;
	logic              at_last_col;

	logic              valid_s1;
	data_t             val_s1;
	row_t              row_s1;
	col_t              col_s1;
	logic              last_row_s1;
	logic              last_col_s1;
	logic              has_right_s1;
	logic              s1_adv;
	logic              load_ok;

	ls_req_t           ls_req;
	ls_rsp_t           ls_rsp;
	group_t            grp;
	logic              row_gt0;
	logic              row_gt1;
	logic              col_gt0;
	logic              col_gt1;

	// out-of-range sizes fall back to the nearest legal one
	always_comb begin
		nr = rows_q;
		if (rows_q == '0) begin
			nr = ROWS_W'(1);
		end else if (rows_q > ROWS_W'(MAX_ROWS)) begin
			nr = ROWS_W'(MAX_ROWS);
		end
		nc = cols_q;
		if (cols_q == '0) begin
			nc = COLS_W'(1);
		end else if (cols_q > COLS_W'(MAX_COLS)) begin
			nc = COLS_W'(MAX_COLS);
		end
	end

	assign at_last_row   = {1'b0, row_q} == nr - ROWS_W'(1);
	assign at_last_col   = {1'b0, col_q} == nc - COLS_W'(1);
	assign cfg.ready     = 1'b1;
	assign cfg_fire      = cfg.valid && cfg.ready;
	assign samples.ready = !valid_s1 || s1_adv;
	assign in_fire       = samples.valid && samples.ready;
	assign s1_adv        = valid_s1 && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= ROWS_W'(1);
			cols_q     <= COLS_W'(1);
			row_q      <= '0;
			col_q      <= '0;
			left_one_q <= '0;
			left_two_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_fire) begin
				unique case (cfg.index)
					REG_ROWS: rows_q <= cfg.data;
					REG_COLS: cols_q <= cfg.data[COLS_W-1:0];
					default: ;
				endcase
				row_q      <= '0;
				col_q      <= '0;
				left_one_q <= '0;
				left_two_q <= '0;
			end else begin
				if (in_fire) begin
					if (at_last_col) begin
						col_q <= '0;
						row_q <= at_last_row ? '0 : row_q + ROW_W'(1);
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
				if (s1_adv) begin
					left_two_q <= left_one_q;
					left_one_q <= val_s1;
				end
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			val_s1       <= samples.value;
			row_s1       <= row_q;
			col_s1       <= col_q;
			last_row_s1  <= at_last_row;
			last_col_s1  <= at_last_col;
			has_right_s1 <= ({1'b0, col_q} + COLS_W'(1)) < nc;
		end
		// above value of the previous column is the up neighbour one column left
		if (s1_adv) begin
			upleft_q <= ls_rsp.above;
		end
	end

	always_comb begin
		ls_req.rd_en    = in_fire;
		ls_req.rd_col   = col_q;
		ls_req.rd_right = col_q + COL_W'(1);
		ls_req.wr_en    = s1_adv;
		ls_req.wr_col   = col_s1;
		ls_req.wr_cur   = val_s1;
		ls_req.wr_above = ls_rsp.above;
	end

	glmd_line_store u_store (
		.clk (clk),
		.req (ls_req),
		.rsp (ls_rsp)
	);

	assign row_gt0 = row_s1 != '0;
	assign row_gt1 = row_s1 > ROW_W'(1);
	assign col_gt0 = col_s1 != '0;
	assign col_gt1 = col_s1 > COL_W'(1);

	always_comb begin
		grp.hit[SLOT_ABOVE] = row_gt0
			&& !(row_gt1 && val_gt(ls_rsp.above, ls_rsp.up))
			&& !val_gt(ls_rsp.above, val_s1)
			&& !(col_gt0 && val_gt(ls_rsp.above, upleft_q))
			&& !(has_right_s1 && val_gt(ls_rsp.above, ls_rsp.right));
		grp.hit[SLOT_LEFT] = last_row_s1 && col_gt0
			&& !(row_gt0 && val_gt(left_one_q, upleft_q))
			&& !(col_gt1 && val_gt(left_one_q, left_two_q))
			&& !val_gt(left_one_q, val_s1);
		grp.hit[SLOT_SELF] = last_row_s1 && last_col_s1
			&& !(row_gt0 && val_gt(val_s1, ls_rsp.above))
			&& !(col_gt0 && val_gt(val_s1, left_one_q));

		grp.slot[SLOT_ABOVE].value = ls_rsp.above;
		grp.slot[SLOT_ABOVE].row   = row_s1 - ROW_W'(1);
		grp.slot[SLOT_ABOVE].col   = col_s1;
		grp.slot[SLOT_LEFT].value  = left_one_q;
		grp.slot[SLOT_LEFT].row    = row_s1;
		grp.slot[SLOT_LEFT].col    = col_s1 - COL_W'(1);
		grp.slot[SLOT_SELF].value  = val_s1;
		grp.slot[SLOT_SELF].row    = row_s1;
		grp.slot[SLOT_SELF].col    = col_s1;
	end

	glmd_result_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (s1_adv),
		.grp     (grp),
		.load_ok (load_ok),
		.minima  (minima)
	);

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < nc)
		else $error("column position beyond matrix width");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, row_q} < nr)
		else $error("row position beyond matrix height");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(minima.valid && !minima.ready) |-> !s1_adv)
		else $error("stage 1 moved while results were still pending");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && minima.valid && !minima.ready) |-> !samples.ready)
		else $error("input taken while stage 1 was stalled");

endmodule

[dv/tb_grid_local_minimum_detector_unit.sv]
// tb_grid_local_minimum_detector_unit: self-checking bench for the 4-neighbour local minimum
// detector; a directed table, then random matrices checked against a line-store predictor.
// Depends on glmd_pkg, glmd_ifs and grid_local_minimum_detector_unit.

module tb_grid_local_minimum_detector_unit import glmd_pkg::*; ;

	localparam int unsigned RANDOM_ITEMS = 385;
	localparam int unsigned CALM_ITEMS   = 50;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned ROWS_RAW_TOP = (1 << ROWS_W) - 1;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_COLS + 1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

	localparam data_t VAL_MIN = {1'b1, {(DATA_W - 1){1'b0}}};
	localparam data_t VAL_MAX = {1'b0, {(DATA_W - 1){1'b1}}};

	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	typedef struct packed {
		result_t res;
		logic    last;
	} min_item_t;

	typedef enum logic {ROW_PIX, ROW_CFG} step_kind_e;

	typedef struct {
		step_kind_e            kind;
		logic [CFG_IDX_W-1:0]  index;
		cfg_data_t             data;
		data_t                 value;
		logic                  typed;
		result_t               want;
	} plan_row_t;

	localparam result_t NO_RESULT = '0;

	// typed rows are 1x1 matrices: each element is its own minimum at the origin
	plan_row_t directed_plan [36] = '{
		'{ROW_PIX, REG_ROWS, '0, 16'sd0, 1'b1, '{16'sd0, 12'd0, 7'd0}},
		'{ROW_PIX, REG_ROWS, '0, VAL_MIN, 1'b1, '{VAL_MIN, 12'd0, 7'd0}},
		'{ROW_PIX, REG_ROWS, '0, VAL_MAX, 1'b1, '{VAL_MAX, 12'd0, 7'd0}},
		'{ROW_CFG, REG_ROWS, 13'd0, 16'sd0, 1'b0, NO_RESULT},
		'{ROW_CFG, REG_COLS, 13'd0, 16'sd0, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, -16'sd1, 1'b1, '{-16'sd1, 12'd0, 7'd0}},
		'{ROW_CFG, REG_SPARE_LAST, 13'h1fff, 16'sd0, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, 16'sh5555, 1'b1, '{16'sh5555, 12'd0, 7'd0}},
		'{ROW_PIX, REG_ROWS, '0, 16'shaaaa, 1'b1, '{16'shaaaa, 12'd0, 7'd0}},
		'{ROW_CFG, REG_ROWS, 13'd2, 16'sd0, 1'b0, NO_RESULT},
		'{ROW_CFG, REG_COLS, 13'h1f02, 16'sd0, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, 16'sd5, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, 16'sd5, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, 16'sd5, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, 16'sd5, 1'b0, NO_RESULT},
		'{ROW_CFG, REG_ROWS, 13'd3, 16'sd0, 1'b0, NO_RESULT},
		'{ROW_CFG, REG_COLS, 13'd3, 16'sd0, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, 16'sd4, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, 16'sd7, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, 16'sd2, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, 16'sd8, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, 16'sd1, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, 16'sd9, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, 16'sd3, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, 16'sd6, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, 16'sd5, 1'b0, NO_RESULT},
		'{ROW_CFG, REG_ROWS, 13'd1, 16'sd0, 1'b0, NO_RESULT},
		'{ROW_CFG, REG_COLS, 13'd4, 16'sd0, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, 16'sd3, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, VAL_MIN, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, VAL_MIN, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, VAL_MAX, 1'b0, NO_RESULT},
		'{ROW_CFG, REG_ROWS, 13'h1fff, 16'sd0, 1'b0, NO_RESULT},
		'{ROW_CFG, REG_COLS, 13'h00ff, 16'sd0, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, VAL_MAX, 1'b0, NO_RESULT},
		'{ROW_PIX, REG_ROWS, '0, VAL_MIN, 1'b0, NO_RESULT}
	};

	logic clk = 1'b0;
	logic arst_n;

	glmd_pix_if samples();
	glmd_min_if minima();
	glmd_cfg_if cfg();

	grid_local_minimum_detector_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples),
		.minima (minima),
		.cfg    (cfg)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [ROWS_W-1:0] rows_reg;
	logic [COLS_W-1:0] cols_reg;
	data_t             older_line [MAX_COLS];
	data_t             upper_line [MAX_COLS];
	int unsigned       row_pos;
	int unsigned       col_pos;
	data_t             left_near;
	data_t             left_far;

	min_item_t   step_minima [$];
	min_item_t   expected_minima [$];
	min_item_t   want;
	int unsigned mismatches = 0;

	logic    typed_on;
	result_t typed_want;
	logic    calm = 1'b0;
	logic    stream_open = 1'b0;
	logic    cfg_open = 1'b0;
	int unsigned ready_hold = 0;
	int unsigned cycle_count = 0;

	function automatic void predict_minima(input data_t v);
		int unsigned nr, nc, r, c;
		data_t up;
		logic bottom, ok;
		nr = (rows_reg == 0) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
		nc = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
		step_minima.delete();
		if (row_pos >= nr || col_pos >= nc) begin
			row_pos = 0;
			col_pos = 0;
		end
		r = row_pos;
		c = col_pos;
		bottom = (r == nr - 1);
		up = upper_line[c];

		// element above now has all four neighbours
		if (r > 0) begin
			ok = !(up > v);
			if (r > 1 && up > older_line[c]) ok = 1'b0;
			if (c > 0 && up > older_line[c - 1]) ok = 1'b0;
			if (c + 1 < nc && up > upper_line[c + 1]) ok = 1'b0;
			if (ok) step_minima.push_back('{'{up, row_t'(r - 1), col_t'(c)}, 1'b0});
		end
		older_line[c] = up;
		upper_line[c] = v;

		if (bottom && c > 0) begin
			ok = !(left_near > v);
			if (r > 0 && left_near > older_line[c - 1]) ok = 1'b0;
			if (c > 1 && left_near > left_far) ok = 1'b0;
			if (ok) step_minima.push_back('{'{left_near, row_t'(r), col_t'(c - 1)}, 1'b0});
		end

		// final element closes the matrix
		if (bottom && c == nc - 1) begin
			ok = 1'b1;
			if (r > 0 && v > up) ok = 1'b0;
			if (c > 0 && v > left_near) ok = 1'b0;
			if (ok) step_minima.push_back('{'{v, row_t'(r), col_t'(c)}, 1'b0});
		end
		if (step_minima.size() != 0) step_minima[step_minima.size() - 1].last = 1'b1;

		left_far = left_near;
		left_near = v;
		col_pos = c + 1;
		if (col_pos >= nc) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= nr) row_pos = 0;
		end
	endfunction

	always @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			predict_minima(samples.value);
			if (typed_on) begin
				expected_minima.push_back('{typed_want, 1'b1});
			end else begin
				foreach (step_minima[i]) expected_minima.push_back(step_minima[i]);
			end
		end
		if (cfg.valid && cfg.ready) begin
			if (cfg.index == REG_ROWS) rows_reg = cfg.data[ROWS_W-1:0];
			else if (cfg.index == REG_COLS) cols_reg = cfg.data[COLS_W-1:0];
			// any write restarts the matrix
			row_pos = 0;
			col_pos = 0;
			left_near = '0;
			left_far = '0;
		end
		if (minima.valid && minima.ready) begin
			if (expected_minima.size() == 0) begin
				$display("%0t: expected no minimum, actual min_value %0d min_row %0d min_col %0d",
					$time, minima.min_value, minima.min_row, minima.min_col);
				mismatches++;
			end else begin
				want = expected_minima.pop_front();
				if (minima.min_value !== want.res.value) begin
					$display("%0t: min_value expected %0d actual %0d",
						$time, want.res.value, minima.min_value);
					mismatches++;
				end
				if (minima.min_row !== want.res.row) begin
					$display("%0t: min_row expected %0d actual %0d",
						$time, want.res.row, minima.min_row);
					mismatches++;
				end
				if (minima.min_col !== want.res.col) begin
					$display("%0t: min_col expected %0d actual %0d",
						$time, want.res.col, minima.min_col);
					mismatches++;
				end
				if (minima.last !== want.last) begin
					$display("%0t: last expected %0b actual %0b", $time, want.last, minima.last);
					mismatches++;
				end
			end
		end
	end

	// random output back-pressure in bursts, none once calm is set
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			minima.ready <= calm || $urandom_range(0, 3) != 0;
			ready_hold <= $urandom_range(0, 15);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_grid_local_minimum_detector_unit: FAIL");
		$finish;
	end

	task automatic settle();
		samples.valid <= 1'b0;
		stream_open = 1'b0;
		// wait for the clock so the last accepted transaction is already in the expected queue
		@(posedge clk);
		while (expected_minima.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input cfg_data_t d);
		if (stream_open) settle();
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		cfg_open = 1'b1;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	task automatic push_value(input data_t v, input logic typed, input result_t t);
		if (cfg_open) begin
			cfg.valid <= 1'b0;
			cfg_open = 1'b0;
		end
		if (!calm && $urandom_range(0, 5) == 0) begin
			samples.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.value <= v;
		typed_on <= typed;
		typed_want <= t;
		stream_open = 1'b1;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
	endtask

	initial begin
		int unsigned random_sent, phase, shape, value_mode, count, nr, nc;
		int unsigned rows_raw, cols_raw;
		data_t v;

		arst_n = 1'b0;
		samples.valid = 1'b0;
		samples.value = '0;
		minima.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_ROWS;
		cfg.data = '0;
		typed_on = 1'b0;
		typed_want = '0;
		rows_reg = 1;
		cols_reg = 1;
		row_pos = 0;
		col_pos = 0;
		left_near = '0;
		left_far = '0;
		foreach (older_line[i]) begin
			older_line[i] = '0;
			upper_line[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_CFG)
				cfg_write(directed_plan[i].index, directed_plan[i].data);
			else
				push_value(directed_plan[i].value, directed_plan[i].typed, directed_plan[i].want);
		end

		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			phase++;
			shape = $urandom_range(0, 9);
			value_mode = $urandom_range(0, 2);
			if (phase == 2) begin
				// full-width matrix, cols written at or above range
				rows_raw = 2;
				cols_raw = MAX_COLS + $urandom_range(0, 127);
				count = 2 * MAX_COLS;
			end else if (shape == 0) begin
				rows_raw = $urandom_range(0, 1) ? MAX_ROWS : $urandom_range(MAX_ROWS + 1, ROWS_RAW_TOP);
				cols_raw = $urandom_range(1, 3);
				count = $urandom_range(4, 20);
			end else begin
				rows_raw = (shape == 1) ? $urandom_range(0, 2) : $urandom_range(1, 6);
				cols_raw = (shape == 1) ? $urandom_range(0, 2) : $urandom_range(1, 8);
				nr = (rows_raw == 0) ? 1 : rows_raw;
				nc = (cols_raw == 0) ? 1 : cols_raw;
				count = nr * nc * $urandom_range(1, 3);
				// short sequence: restart before the matrix completes, or just as it does
				if ($urandom_range(0, 4) == 0) count = $urandom_range(1, nr * nc);
			end

			if ($urandom_range(0, 5) == 0)
				cfg_write(CFG_IDX_W'(REG_SPARE_FIRST
					+ $urandom_range(0, REG_SPARE_LAST - REG_SPARE_FIRST)),
					cfg_data_t'($urandom));
			if ($urandom_range(0, 1)) cfg_write(REG_ROWS, cfg_data_t'(rows_raw));
			cfg_write(REG_COLS, cfg_data_t'(($urandom_range(0, 31) << COLS_W) | cols_raw));
			cfg_write(REG_ROWS, cfg_data_t'(rows_raw));

			repeat (count) begin
				if (random_sent >= RANDOM_ITEMS) break;
				calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
				case (value_mode)
					0: v = data_t'($urandom);
					1: v = data_t'(int'($urandom_range(0, 3)) - 2);
					default: begin
						case ($urandom_range(0, 2))
							0: v = VAL_MIN;
							1: v = VAL_MAX;
							default: v = data_t'($urandom);
						endcase
					end
				endcase
				push_value(v, 1'b0, NO_RESULT);
				random_sent++;
			end
		end

		settle();
		if (mismatches == 0 && expected_minima.size() == 0) begin
			$display("tb_grid_local_minimum_detector_unit: PASS");
		end else begin
			$display("tb_grid_local_minimum_detector_unit: FAIL");
		end
		$finish;
	end

endmodule

[grid_local_minimum_detector_unit.f]
rtl/glmd_pkg.sv
rtl/glmd_ifs.sv
rtl/glmd_line_store.sv
rtl/glmd_result_queue.sv
rtl/grid_local_minimum_detector_unit.sv
dv/tb_grid_local_minimum_detector_unit.sv
